// File: rtl/core/ssl_pkg.sv
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared types and constants for the strongest source list: op codes, result
// kinds, register map, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ssl_pkg;

  // Default sizing
  localparam int unsigned SlotsDef   = 8;
  localparam int unsigned SourcesDef = 256;

  // Register reset values (0.005 in Q16.16, rounded)
  localparam logic [31:0] IgnoreLimitRst = 32'd328;
  localparam logic        TrackEnRst     = 1'b1;

  // Register map, selected by paddr[2]
  localparam logic REG_IGNORE_LIMIT = 1'b0;
  localparam logic REG_TRACK_EN     = 1'b1;

  // Result kinds
  localparam logic KIND_OFFER = 1'b0;
  localparam logic KIND_SLOT  = 1'b1;

  // Divider: 32 quotient bits, one per cycle
  localparam int unsigned DivSteps = 32;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_OFFER = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } ssl_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_REPLY,
    ST_READ
  } ssl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic capture;
    logic div_start;
    logic scan_start;
    logic scan_step;
    logic reply;
    logic read_start;
    logic read_beat;
  } ssl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pre_reject;
    logic div_done;
    logic keep;
    logic full;
    logic scan_last;
    logic read_last;
    logic out_free;
  } ssl_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/ssl_divider.sv
// ----------------------------------------------------------------------------
// ssl_divider
// Restoring radix-2 divider: 32-bit dividend by 16-bit divisor, one quotient
// bit per cycle. Quotient holds after done until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quotient_o
);
  import ssl_pkg::*;

  localparam int unsigned CntW = $clog2(DivSteps);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     rem_q, rem_d;
  logic [31:0]     quo_q, quo_d;
  logic [15:0]     dsr_q, dsr_d;
  logic [16:0]     trial;
  logic [16:0]     diff;
  logic            ge;
  logic            last_step;

  // One restoring step: shift in the next dividend bit, try a subtract
  assign trial     = {rem_q, quo_q[31]};
  assign ge        = trial >= {1'b0, dsr_q};
  assign diff      = trial - {1'b0, dsr_q};
  assign last_step = cnt_q == CntW'(DivSteps - 1);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[15:0] : trial[15:0];
      quo_d = {quo_q[30:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: rtl/core/ssl_datapath.sv
// ----------------------------------------------------------------------------
// ssl_datapath
// Slot storage, entry count, weakest-slot scan, effect divider and the output
// register. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_datapath #(
  parameter int unsigned SLOTS   = ssl_pkg::SlotsDef,
  parameter int unsigned SOURCES = ssl_pkg::SourcesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ssl_pkg::ssl_cmd_t cmd_i,
  output ssl_pkg::ssl_sts_t      sts_o,
  input  wire logic [7:0]        source_index_i,
  input  wire logic [15:0]       strength_i,
  input  wire logic [15:0]       distance_i,
  input  wire logic [31:0]       ignore_limit_i,
  input  wire logic              track_en_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic                   kind_o,
  output logic                   accepted_o,
  output logic [2:0]             slot_o,
  output logic                   filled_o,
  output logic [7:0]             stored_source_o,
  output logic [31:0]            stored_effect_o,
  output logic                   last_o
);
  import ssl_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned ExtW = IdxW + 3;

  // Slot storage
  logic [7:0]      src_mem [SLOTS];
  logic [31:0]     eff_mem [SLOTS];

  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [31:0]     min_q, min_d;
  logic [7:0]      src_q;
  logic            reject_q, reject_d;

  logic            out_valid_q, out_valid_d;
  logic            kind_q, accepted_q, filled_q, last_q;
  logic [2:0]      slot_q;
  logic [7:0]      ssrc_q;
  logic [31:0]     seff_q;

  logic [15:0]     divisor;
  logic            div_done;
  logic [31:0]     quotient;
  logic [7:0]      rd_src;
  logic [31:0]     rd_eff;
  logic            full;
  logic            keep;
  logic            out_free;
  logic            rd_filled;
  logic [IdxW-1:0] wr_pos;
  logic [ExtW-1:0] wr_pos_ext;
  logic [ExtW-1:0] idx_ext;
  logic            do_write;

  // Clamp distance to at least one
  assign divisor = (distance_i == 16'd0) ? 16'd1 : distance_i;

  ssl_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({strength_i, 16'd0}),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Single read port, shared by scan and readout
  assign rd_src = src_mem[idx_q];
  assign rd_eff = eff_mem[idx_q];

  assign full       = count_q == CntW'(SLOTS);
  assign keep       = quotient >= ignore_limit_i;
  assign out_free   = !out_valid_q || out_ready_i;
  assign rd_filled  = CntW'(idx_q) < count_q;
  assign wr_pos     = full ? pos_q : count_q[IdxW-1:0];
  assign wr_pos_ext = ExtW'(wr_pos);
  assign idx_ext    = ExtW'(idx_q);
  assign do_write   = cmd_i.reply && !reject_q;

  // Status
  always_comb begin
    sts_o.pre_reject = !track_en_i || (strength_i == 16'd0) ||
                       (32'(source_index_i) >= 32'(SOURCES));
    sts_o.div_done   = div_done;
    sts_o.keep       = keep;
    sts_o.full       = full;
    sts_o.scan_last  = idx_q == IdxW'(SLOTS - 1);
    sts_o.read_last  = idx_q == IdxW'(SLOTS - 1);
    sts_o.out_free   = out_free;
  end

  // Control register next values
  always_comb begin
    count_d  = count_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    min_d    = min_q;
    reject_d = reject_q;
    if (cmd_i.clear && track_en_i) begin
      count_d = '0;
    end
    if (cmd_i.capture) begin
      reject_d = sts_o.pre_reject;
    end
    if (div_done) begin
      reject_d = !keep;
    end
    // Scan for the first weakest slot
    if (cmd_i.scan_start) begin
      idx_d = '0;
      pos_d = '0;
      min_d = '1;
    end
    if (cmd_i.scan_step) begin
      if (rd_eff < min_q) begin
        min_d = rd_eff;
        pos_d = idx_q;
      end
      idx_d = idx_q + IdxW'(1);
    end
    if (cmd_i.read_start) begin
      idx_d = '0;
    end
    if (cmd_i.read_beat) begin
      idx_d = idx_q + IdxW'(1);
    end
    if (do_write && !full) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      reject_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      reject_q    <= reject_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q <= min_d;
    if (cmd_i.capture) begin
      src_q <= source_index_i;
    end
  end

  // Store an accepted source
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      src_mem[wr_pos] <= src_q;
      eff_mem[wr_pos] <= quotient;
    end
  end

  // Output register: load a reply or one readout slot, drop on a taken beat
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.reply || cmd_i.read_beat) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.reply) begin
      kind_q     <= KIND_OFFER;
      accepted_q <= !reject_q;
      slot_q     <= reject_q ? 3'd0 : wr_pos_ext[2:0];
      filled_q   <= 1'b0;
      ssrc_q     <= reject_q ? 8'd0 : src_q;
      seff_q     <= reject_q ? 32'd0 : quotient;
      last_q     <= 1'b1;
    end else if (cmd_i.read_beat) begin
      kind_q     <= KIND_SLOT;
      accepted_q <= 1'b0;
      slot_q     <= idx_ext[2:0];
      filled_q   <= rd_filled;
      ssrc_q     <= rd_filled ? rd_src : 8'd0;
      seff_q     <= rd_filled ? rd_eff : 32'd0;
      last_q     <= sts_o.read_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign accepted_o      = accepted_q;
  assign slot_o          = slot_q;
  assign filled_o        = filled_q;
  assign stored_source_o = ssrc_q;
  assign stored_effect_o = seff_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire

// File: rtl/core/ssl_ctrl.sv
// ----------------------------------------------------------------------------
// ssl_ctrl
// Controller state machine: takes input beats, sequences divide, scan, reply
// and readout through commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        op_i,
  output logic                   in_ready_o,
  output ssl_pkg::ssl_cmd_t      cmd_o,
  input  wire ssl_pkg::ssl_sts_t sts_i
);
  import ssl_pkg::*;

  ssl_state_e state_q, state_d;
  ssl_op_e    op;

  assign op = ssl_op_e'(op_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op)
            OP_OFFER: state_d = sts_i.pre_reject ? ST_REPLY : ST_DIV;
            OP_READ:  state_d = ST_READ;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = (sts_i.keep && sts_i.full) ? ST_SCAN : ST_REPLY;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (sts_i.out_free && sts_i.read_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (op)
            OP_CLEAR: cmd_o.clear = 1'b1;
            OP_OFFER: begin
              cmd_o.capture   = 1'b1;
              cmd_o.div_start = !sts_i.pre_reject;
            end
            OP_READ:  cmd_o.read_start = 1'b1;
            default:  cmd_o = '0;
          endcase
        end
      end
      ST_DIV: begin
        cmd_o.scan_start = sts_i.div_done && sts_i.keep && sts_i.full;
      end
      ST_SCAN:  cmd_o.scan_step = 1'b1;
      ST_REPLY: cmd_o.reply     = sts_i.out_free;
      ST_READ:  cmd_o.read_beat = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/strongest_source_list.sv
// ----------------------------------------------------------------------------
// strongest_source_list
// Top level: register port, controller and datapath of a fixed-size list of
// the strongest light sources reaching one surface.
// ----------------------------------------------------------------------------
// The list holds up to SLOTS sources with their Q16.16 effect (strength over
// distance). A clear gives no result. An offer that passes the early checks
// (tracking on, nonzero strength, index in range) goes through the bit-serial
// divider, then, when the list is full and the effect meets the ignore limit,
// through the weakest-slot scan, and returns one reply. An offer that fails
// the early checks skips the divider and also returns one reply.
// A readout returns SLOTS beats, one per cycle while the
// output side takes them. One item is in work at a time; a finished beat sits
// in an output register, and the next item is taken once the last beat of the
// current one is loaded there. Write the registers only while the block is idle.
`default_nettype none

module strongest_source_list #(
  parameter int unsigned SLOTS   = ssl_pkg::SlotsDef,
  parameter int unsigned SOURCES = ssl_pkg::SourcesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  source_index_i,
  input  wire logic [15:0] strength_i,
  input  wire logic [15:0] distance_i,
  // Output channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic             accepted_o,
  output logic [2:0]       slot_o,
  output logic             filled_o,
  output logic [7:0]       stored_source_o,
  output logic [31:0]      stored_effect_o,
  output logic             last_o
);
  import ssl_pkg::*;

  logic [31:0] ignore_limit_q, ignore_limit_d;
  logic        track_en_q, track_en_d;
  logic        reg_wr;
  ssl_cmd_t    cmd;
  ssl_sts_t    sts;

  // Register writes
  assign reg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    ignore_limit_d = ignore_limit_q;
    track_en_d     = track_en_q;
    if (reg_wr) begin
      case (paddr[2])
        REG_IGNORE_LIMIT: ignore_limit_d = pwdata;
        REG_TRACK_EN:     track_en_d     = pwdata[0];
        default:          ignore_limit_d = ignore_limit_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_limit_q <= IgnoreLimitRst;
      track_en_q     <= TrackEnRst;
    end else begin
      ignore_limit_q <= ignore_limit_d;
      track_en_q     <= track_en_d;
    end
  end

  // Register reads
  always_comb begin
    case (paddr[2])
      REG_IGNORE_LIMIT: prdata = ignore_limit_q;
      REG_TRACK_EN:     prdata = {31'd0, track_en_q};
      default:          prdata = '0;
    endcase
  end

  ssl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  ssl_datapath #(
    .SLOTS   (SLOTS),
    .SOURCES (SOURCES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .source_index_i  (source_index_i),
    .strength_i      (strength_i),
    .distance_i      (distance_i),
    .ignore_limit_i  (ignore_limit_q),
    .track_en_i      (track_en_q),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .accepted_o      (accepted_o),
    .slot_o          (slot_o),
    .filled_o        (filled_o),
    .stored_source_o (stored_source_o),
    .stored_effect_o (stored_effect_o),
    .last_o          (last_o)
  );

  // A readout keeps the input closed until its last slot is loaded for output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == OP_READ) |=> !in_ready_o)
    else $error("input taken during readout");

  // A stored source always meets the ignore limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_OFFER) && accepted_o |->
      stored_effect_o >= ignore_limit_q)
    else $error("accepted source below ignore limit");

  // An empty slot reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_SLOT) && !filled_o |->
      (stored_effect_o == 32'd0) && (stored_source_o == 8'd0))
    else $error("empty slot carries data");

  // An offer reply is the only beat of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_OFFER) |-> last_o && !filled_o)
    else $error("offer reply not marked last");

endmodule

`default_nettype wire

// File: bench/strongest_source_list_test.sv
// ----------------------------------------------------------------------------
// strongest_source_list_test
// Self-checking bench for the strongest source list. A short table of offers,
// clears and readouts opens the run, then random traffic runs under several
// register settings. Every beat on the result side is compared field by field
// with a behavioral copy of the list kept in step with the accepted requests.
// ----------------------------------------------------------------------------

module strongest_source_list_test;

  timeunit 1ns;
  timeprecision 1ps;

  import ssl_pkg::*;

  localparam int unsigned SLOTS       = SlotsDef;
  localparam int unsigned SOURCES     = SourcesDef;
  localparam int          SETTLE      = 64;       // divider, scan and margin
  localparam int          CYCLE_LIMIT = 400000;

  localparam logic [2:0] ADDR_LIMIT = {REG_IGNORE_LIMIT, 2'b00};
  localparam logic [2:0] ADDR_TRACK = {REG_TRACK_EN, 2'b00};

  // One request to the list; the t_ fields hold a hand-written reply
  typedef struct {
    ssl_op_e     op;
    logic [7:0]  idx;
    logic [15:0] str;
    logic [15:0] distance;
    bit          typed;
    logic        t_acc;
    logic [2:0]  t_slot;
    logic [31:0] t_eff;
  } source_req_t;

  // One result beat
  typedef struct packed {
    logic        kind;
    logic        accepted;
    logic [2:0]  slot;
    logic        filled;
    logic [7:0]  src;
    logic [31:0] effect;
    logic        last;
  } slot_beat_t;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [2:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i            = '0;
  logic [7:0]  source_index_i  = '0;
  logic [15:0] strength_i      = '0;
  logic [15:0] distance_i      = '0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic        kind_o;
  logic        accepted_o;
  logic [2:0]  slot_o;
  logic        filled_o;
  logic [7:0]  stored_source_o;
  logic [31:0] stored_effect_o;
  logic        last_o;

  // Shadow of the list and its registers
  logic [7:0]  list_src [SLOTS];
  logic [31:0] list_eff [SLOTS];
  int          list_count  = 0;
  logic [31:0] ignore_lim  = IgnoreLimitRst;
  logic        track_en    = TrackEnRst;

  slot_beat_t  beats_due [$];
  slot_beat_t  head;
  int          mismatch_count = 0;
  int          beats_seen     = 0;
  int          offers_stored  = 0;
  int          offers_dropped = 0;
  int          replacements   = 0;
  int          readouts       = 0;
  int          cycle_count    = 0;
  int          burst_left     = 0;
  int          rdy_hold       = 0;

  // Opening table: reset contents, field extremes, the ignore limit edge,
  // a full list with replacement and ties, the unused op code and a clear
  source_req_t opening_rows [21] = '{
    '{OP_READ,  8'h00, 16'h0000, 16'h0000, 1'b1, 1'b0, 3'd0, 32'h0000_0000},
    '{OP_OFFER, 8'h00, 16'h0000, 16'h0005, 1'b1, 1'b0, 3'd0, 32'h0000_0000},
    '{OP_OFFER, 8'hFF, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 3'd0, 32'hFFFF_0000},
    '{OP_OFFER, 8'h01, 16'h0001, 16'hFFFF, 1'b1, 1'b0, 3'd0, 32'h0000_0000},
    '{OP_OFFER, 8'h02, 16'h0001, 16'h0001, 1'b1, 1'b1, 3'd1, 32'h0001_0000},
    '{OP_OFFER, 8'h03, 16'h0001, 16'd200,  1'b1, 1'b0, 3'd0, 32'h0000_0000},
    '{OP_OFFER, 8'h04, 16'h0001, 16'd199,  1'b1, 1'b1, 3'd2, 32'd329},
    '{OP_OFFER, 8'h55, 16'hAAAA, 16'h5555, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{OP_OFFER, 8'hAA, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{OP_OFFER, 8'h07, 16'd100,  16'd3,    1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{OP_OFFER, 8'h08, 16'd50,   16'd1,    1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{OP_OFFER, 8'h09, 16'd2,    16'd1,    1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{OP_READ,  8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{OP_OFFER, 8'h0A, 16'd3,    16'd1,    1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{OP_OFFER, 8'h0B, 16'd1,    16'd1,    1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{OP_OFFER, 8'h0C, 16'd1,    16'd1,    1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{OP_NONE,  8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{OP_READ,  8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{OP_CLEAR, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{OP_READ,  8'h00, 16'h0000, 16'h0000, 1'b1, 1'b0, 3'd0, 32'h0000_0000},
    '{OP_OFFER, 8'h0D, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 3'd0, 32'h0001_0000}
  };

  strongest_source_list DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .source_index_i (source_index_i),
    .strength_i     (strength_i),
    .distance_i     (distance_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .accepted_o     (accepted_o),
    .slot_o         (slot_o),
    .filled_o       (filled_o),
    .stored_source_o(stored_source_o),
    .stored_effect_o(stored_effect_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Predict the beats one accepted request causes and advance the shadow list
  task automatic list_model(input ssl_op_e op, input logic [7:0] idx, input logic [15:0] str,
                            input logic [15:0] distance, output slot_beat_t beats[$]);
    logic [31:0] divisor;
    logic [31:0] eff;
    int          pos;
    beats.delete();
    case (op)
      OP_CLEAR: begin
        if (track_en) list_count = 0;
      end
      OP_OFFER: begin
        divisor = (distance == 16'd0) ? 32'd1 : {16'd0, distance};
        eff = {str, 16'd0} / divisor;
        if (!track_en || str == 16'd0 || idx >= SOURCES || eff < ignore_lim) begin
          beats.push_back('{KIND_OFFER, 1'b0, 3'd0, 1'b0, 8'd0, 32'd0, 1'b1});
          offers_dropped++;
        end else begin
          if (list_count < SLOTS) begin
            pos = list_count;
            list_count++;
          end else begin
            // take the first weakest slot
            pos = 0;
            for (int i = 1; i < SLOTS; i++)
              if (list_eff[i] < list_eff[pos]) pos = i;
            replacements++;
          end
          list_src[pos] = idx;
          list_eff[pos] = eff;
          beats.push_back('{KIND_OFFER, 1'b1, 3'(pos), 1'b0, idx, eff, 1'b1});
          offers_stored++;
        end
      end
      OP_READ: begin
        for (int k = 0; k < SLOTS; k++) begin
          if (k < list_count)
            beats.push_back('{KIND_SLOT, 1'b0, 3'(k), 1'b1, list_src[k], list_eff[k],
                              k == SLOTS - 1});
          else
            beats.push_back('{KIND_SLOT, 1'b0, 3'(k), 1'b0, 8'd0, 32'd0, k == SLOTS - 1});
        end
        readouts++;
      end
      default: ;
    endcase
  endtask

  // Drive one request, hold it until the beat is taken, then queue its results
  task automatic issue(input source_req_t it);
    slot_beat_t want [$];
    int         gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(5, 20);
      gap = 0;
    end else begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : gap_len();
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= it.op;
    source_index_i <= it.idx;
    strength_i     <= it.str;
    distance_i     <= it.distance;
    do @(posedge clk_i); while (!in_ready_o);

    list_model(it.op, it.idx, it.str, it.distance, want);
    if (it.typed) begin
      // hand-written reply replaces the prediction
      want.delete();
      if (it.op == OP_READ) begin
        for (int k = 0; k < SLOTS; k++)
          want.push_back('{KIND_SLOT, 1'b0, 3'(k), 1'b0, 8'd0, 32'd0, k == SLOTS - 1});
      end else begin
        want.push_back('{KIND_OFFER, it.t_acc, it.t_slot, 1'b0, it.t_acc ? it.idx : 8'd0,
                         it.t_eff, 1'b1});
      end
    end
    foreach (want[k]) beats_due.push_back(want[k]);
  endtask

  // Hold the sender until every pending beat has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (beats_due.size() != 0);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_LIMIT) ignore_lim = data;
    else track_en = data[0];
  endtask

  // Reconfigure while idle, then run random requests
  task automatic run_phase(input logic [31:0] lim, input logic en, input int n, input int pause_at);
    source_req_t it;
    int          pick;
    drain();
    repeat (SETTLE) @(posedge clk_i);
    reg_write(ADDR_LIMIT, lim);
    reg_write(ADDR_TRACK, {31'd0, en});
    for (int j = 0; j < n; j++) begin
      if (j == pause_at) drain();
      pick = $urandom_range(0, 99);
      if (pick < 5) it.op = OP_CLEAR;
      else if (pick < 9) it.op = OP_NONE;
      else if (pick < 25) it.op = OP_READ;
      else it.op = OP_OFFER;
      it.idx = 8'($urandom());
      case ($urandom_range(0, 9))
        0: begin
          it.str      = 16'd0;
          it.distance = 16'($urandom());
        end
        1: begin
          it.str      = 16'hFFFF;
          it.distance = 16'($urandom_range(0, 3));
        end
        2: begin
          it.str      = 16'($urandom());
          it.distance = 16'hFFFF;
        end
        // coarse ratios give many equal effects
        3, 4: begin
          it.str      = 16'($urandom_range(1, 3));
          it.distance = 16'($urandom_range(0, 2));
        end
        default: begin
          it.str      = 16'($urandom());
          it.distance = 16'($urandom_range(0, 16'hFFFF) >> $urandom_range(0, 15));
        end
      endcase
      it.typed  = 1'b0;
      it.t_acc  = 1'b0;
      it.t_slot = 3'd0;
      it.t_eff  = 32'd0;
      issue(it);
    end
  endtask

  // Stall the result side: short and long gaps, with stretches held ready
  always @(posedge clk_i) begin
    if (rdy_hold != 0) begin
      rdy_hold <= rdy_hold - 1;
    end else if (!out_ready_i) begin
      out_ready_i <= 1'b1;
      rdy_hold    <= $urandom_range(0, 12);
    end else if ($urandom_range(0, 7) == 0) begin
      rdy_hold <= $urandom_range(20, 60);
    end else begin
      out_ready_i <= 1'b0;
      rdy_hold    <= gap_len() - 1;
    end
  end

  // Compare each taken beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (beats_due.size() == 0) begin
        $error("result beat with nothing pending: kind %0d slot %0d", kind_o, slot_o);
        mismatch_count++;
      end else begin
        head = beats_due.pop_front();
        check_field("kind", head.kind, kind_o);
        check_field("accepted", head.accepted, accepted_o);
        check_field("slot", head.slot, slot_o);
        check_field("filled", head.filled, filled_o);
        check_field("stored_source", head.src, stored_source_o);
        check_field("stored_effect", head.effect, stored_effect_o);
        check_field("last", head.last, last_o);
        beats_seen++;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d beats pending", cycle_count, beats_due.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening under reset settings
    foreach (opening_rows[r]) issue(opening_rows[r]);

    // random traffic over register extremes and mid settings
    run_phase(32'h0000_0000, 1'b1, 40, -1);
    run_phase(32'hFFFF_FFFF, 1'b1, 12, -1);
    run_phase($urandom_range(0, 32'h0004_0000), 1'b0, 25, -1);
    run_phase($urandom_range(0, 32'h0004_0000), 1'b1, 60, 30);
    run_phase(IgnoreLimitRst, 1'b1, 63, 20);

    drain();
    repeat (SETTLE) @(posedge clk_i);

    $display("offers: %0d stored (%0d over a full list), %0d dropped; %0d readouts",
             offers_stored, replacements, offers_dropped, readouts);
    $display("%0d result beats checked in %0d cycles", beats_seen, cycle_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ssl_pkg.sv
rtl/core/ssl_divider.sv
rtl/core/ssl_datapath.sv
rtl/core/ssl_ctrl.sv
rtl/core/strongest_source_list.sv
bench/strongest_source_list_test.sv
